// ===== design/qrs_pkg.sv =====
package qrs_pkg;

    // Word format of coefficients and roots.
    localparam int WORD_WIDTH = 32;
    localparam int FRAC_BITS  = 16;

    // Product and discriminant widths.
    localparam int PROD_W = 2 * WORD_WIDTH;
    localparam int DISC_W = PROD_W + 1;

    // Square root: one result bit per stage, two radicand bits consumed per stage.
    localparam int SQ_STEPS = (DISC_W + 1) / 2;
    localparam int RAD_W    = 2 * SQ_STEPS;
    localparam int ROOT_W   = SQ_STEPS;
    localparam int SREM_W   = ROOT_W + 3;

    // Division: numerator magnitude, dividend, divisor and partial remainder.
    localparam int NUM_W  = ROOT_W + 1;
    localparam int X_W    = NUM_W + FRAC_BITS + 1;
    localparam int DVS_W  = WORD_WIDTH + 1;
    localparam int DREM_W = DVS_W + 1;

    // Three quotients per equation: first numerator, second numerator, imaginary part.
    localparam int LANES = 3;

    // Root classification codes.
    localparam logic [1:0] KIND_DISTINCT = 2'd0;
    localparam logic [1:0] KIND_DOUBLE   = 2'd1;
    localparam logic [1:0] KIND_COMPLEX  = 2'd2;
    localparam logic [1:0] KIND_REJECT   = 2'd3;

    typedef struct packed {
        logic signed [WORD_WIDTH-1:0] coef_a;
        logic signed [WORD_WIDTH-1:0] coef_b;
        logic signed [WORD_WIDTH-1:0] coef_c;
    } in_t;

    typedef struct packed {
        logic signed [WORD_WIDTH-1:0] root1_re;
        logic signed [WORD_WIDTH-1:0] root1_im;
        logic signed [WORD_WIDTH-1:0] root2_re;
        logic signed [WORD_WIDTH-1:0] root2_im;
        logic [1:0]                   root_kind;
        logic                         clipped;
    } out_t;

    // Sign-magnitude view of the coefficients that travels with the discriminant.
    typedef struct packed {
        logic                  a_neg;
        logic                  a_zero;
        logic                  nb_neg;
        logic                  ac_neg;
        logic                  d_neg;
        logic [WORD_WIDTH-1:0] a_mag;
        logic [WORD_WIDTH-1:0] b_mag;
    } coef_t;

    // Side information that travels with the quotients.
    typedef struct packed {
        logic [1:0]       kind;
        logic [LANES-1:0] q_neg;
    } dctl_t;

endpackage

// ===== design/qrs_front.sv =====
module qrs_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        adv,
    input  logic                        in_valid,
    input  qrs_pkg::in_t                in_data,
    output logic                        d_valid,
    output logic [qrs_pkg::DISC_W-1:0]  d_mag,
    output qrs_pkg::coef_t              d_ctl
);
    import qrs_pkg::*;

    logic                  s1_valid_reg;
    in_t                   s1_data_reg;
    logic                  s2_valid_reg;
    logic [PROD_W-1:0]     b2_reg;
    logic [PROD_W-1:0]     ac_reg;
    coef_t                 s2_ctl_reg;
    logic                  s3_valid_reg;
    logic [DISC_W-1:0]     dmag_reg;
    coef_t                 s3_ctl_reg;

    logic [WORD_WIDTH-1:0] a_raw;
    logic [WORD_WIDTH-1:0] b_raw;
    logic [WORD_WIDTH-1:0] c_raw;
    logic [WORD_WIDTH-1:0] a_mag;
    logic [WORD_WIDTH-1:0] b_mag;
    logic [WORD_WIDTH-1:0] c_mag;
    logic [PROD_W-1:0]     b2_next;
    logic [PROD_W-1:0]     ac_next;
    coef_t                 s2_ctl_next;

    logic [PROD_W+1:0]     b2_ext;
    logic [PROD_W+1:0]     ac4;
    logic [PROD_W+1:0]     d_sum;
    logic [PROD_W+1:0]     d_pos;
    logic [PROD_W+1:0]     d_negv;
    logic                  b2_ge;
    logic [DISC_W-1:0]     dmag_next;
    coef_t                 s3_ctl_next;

    // Sign-magnitude split of the registered coefficients.
    always_comb
    begin
        a_raw = s1_data_reg.coef_a;
        b_raw = s1_data_reg.coef_b;
        c_raw = s1_data_reg.coef_c;
        a_mag = a_raw[WORD_WIDTH-1] ? (~a_raw + 1'b1) : a_raw;
        b_mag = b_raw[WORD_WIDTH-1] ? (~b_raw + 1'b1) : b_raw;
        c_mag = c_raw[WORD_WIDTH-1] ? (~c_raw + 1'b1) : c_raw;
    end

    // Unsigned products b*b and a*c.
    always_comb
    begin
        b2_next            = PROD_W'(b_mag) * PROD_W'(b_mag);
        ac_next            = PROD_W'(a_mag) * PROD_W'(c_mag);
        s2_ctl_next.a_neg  = a_raw[WORD_WIDTH-1];
        s2_ctl_next.a_zero = (a_mag == '0);
        s2_ctl_next.nb_neg = ~b_raw[WORD_WIDTH-1];
        s2_ctl_next.ac_neg = a_raw[WORD_WIDTH-1] ^ c_raw[WORD_WIDTH-1];
        s2_ctl_next.d_neg  = 1'b0;
        s2_ctl_next.a_mag  = a_mag;
        s2_ctl_next.b_mag  = b_mag;
    end

    // Discriminant magnitude and sign from b*b and 4*a*c.
    always_comb
    begin
        b2_ext      = (PROD_W+2)'(b2_reg);
        ac4         = {ac_reg, 2'b00};
        d_sum       = b2_ext + ac4;
        d_pos       = b2_ext - ac4;
        d_negv      = ac4 - b2_ext;
        b2_ge       = (b2_ext >= ac4);
        s3_ctl_next = s2_ctl_reg;
        if (s2_ctl_reg.ac_neg)
        begin
            dmag_next         = d_sum[DISC_W-1:0];
            s3_ctl_next.d_neg = 1'b0;
        end
        else if (b2_ge)
        begin
            dmag_next         = d_pos[DISC_W-1:0];
            s3_ctl_next.d_neg = 1'b0;
        end
        else
        begin
            dmag_next         = d_negv[DISC_W-1:0];
            s3_ctl_next.d_neg = 1'b1;
        end
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_data_reg <= in_data;
            b2_reg      <= b2_next;
            ac_reg      <= ac_next;
            s2_ctl_reg  <= s2_ctl_next;
            dmag_reg    <= dmag_next;
            s3_ctl_reg  <= s3_ctl_next;
        end
    end

    assign d_valid = s3_valid_reg;
    assign d_mag   = dmag_reg;
    assign d_ctl   = s3_ctl_reg;

endmodule

// ===== design/qrs_sqrt.sv =====
module qrs_sqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        adv,
    input  logic                        d_valid,
    input  logic [qrs_pkg::DISC_W-1:0]  d_mag,
    input  qrs_pkg::coef_t              d_ctl,
    output logic                        s_valid,
    output logic [qrs_pkg::ROOT_W-1:0]  s_root,
    output qrs_pkg::coef_t              s_ctl
);
    import qrs_pkg::*;

    localparam int LAST = SQ_STEPS - 1;

    logic              vld_in    [SQ_STEPS];
    logic              vld_reg   [SQ_STEPS];
    coef_t             ctl_in    [SQ_STEPS];
    coef_t             ctl_reg   [SQ_STEPS];
    logic [SREM_W-1:0] rem_in    [SQ_STEPS];
    logic [SREM_W-1:0] rem_next  [SQ_STEPS];
    logic [SREM_W-1:0] rem_reg   [SQ_STEPS];
    logic [ROOT_W-1:0] root_in   [SQ_STEPS];
    logic [ROOT_W-1:0] root_next [SQ_STEPS];
    logic [ROOT_W-1:0] root_reg  [SQ_STEPS];
    logic [RAD_W-1:0]  rad_in    [SQ_STEPS];
    logic [RAD_W-1:0]  rad_next  [SQ_STEPS];
    logic [RAD_W-1:0]  rad_reg   [SQ_STEPS];

    logic              rnd_valid_reg;
    logic [ROOT_W-1:0] rnd_root_reg;
    coef_t             rnd_ctl_reg;
    logic              round_up;

    // One result bit per stage: shift in two radicand bits and try root*4+1.
    genvar k;
    for (k = 0; k < SQ_STEPS; k++)
    begin : g_stage
        logic [SREM_W-1:0] rem_sh;
        logic [SREM_W-1:0] trial;
        logic              ge;

        if (k == 0)
        begin : g_first
            assign vld_in[k]  = d_valid;
            assign ctl_in[k]  = d_ctl;
            assign rem_in[k]  = '0;
            assign root_in[k] = '0;
            assign rad_in[k]  = RAD_W'(d_mag);
        end
        else
        begin : g_later
            assign vld_in[k]  = vld_reg[k-1];
            assign ctl_in[k]  = ctl_reg[k-1];
            assign rem_in[k]  = rem_reg[k-1];
            assign root_in[k] = root_reg[k-1];
            assign rad_in[k]  = rad_reg[k-1];
        end

        assign rem_sh       = {rem_in[k][SREM_W-3:0], rad_in[k][RAD_W-1 -: 2]};
        assign trial        = SREM_W'({root_in[k], 2'b01});
        assign ge           = (rem_sh >= trial);
        assign rem_next[k]  = ge ? (rem_sh - trial) : rem_sh;
        assign root_next[k] = {root_in[k][ROOT_W-2:0], ge};
        assign rad_next[k]  = {rad_in[k][RAD_W-3:0], 2'b00};
    end

    // The final remainder is D minus root squared; round up when it exceeds the root.
    assign round_up = (rem_reg[LAST] > SREM_W'(root_reg[LAST]));

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SQ_STEPS; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
            rnd_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            for (int i = 0; i < SQ_STEPS; i++)
            begin
                vld_reg[i] <= vld_in[i];
            end
            rnd_valid_reg <= vld_reg[LAST];
        end
    end

    // Stage payload registers.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < SQ_STEPS; i++)
            begin
                rem_reg[i]  <= rem_next[i];
                root_reg[i] <= root_next[i];
                rad_reg[i]  <= rad_next[i];
                ctl_reg[i]  <= ctl_in[i];
            end
            rnd_root_reg <= root_reg[LAST] + ROOT_W'(round_up);
            rnd_ctl_reg  <= ctl_reg[LAST];
        end
    end

    assign s_valid = rnd_valid_reg;
    assign s_root  = rnd_root_reg;
    assign s_ctl   = rnd_ctl_reg;

endmodule

// ===== design/qrs_div.sv =====
module qrs_div (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          adv,
    input  logic                                          s_valid,
    input  logic [qrs_pkg::ROOT_W-1:0]                    s_root,
    input  qrs_pkg::coef_t                                s_ctl,
    output logic                                          q_valid,
    output logic [qrs_pkg::LANES-1:0][qrs_pkg::X_W-1:0]   q_quot,
    output qrs_pkg::dctl_t                                q_ctl
);
    import qrs_pkg::*;

    localparam int LAST = X_W - 1;

    typedef struct packed {
        logic             neg;
        logic [NUM_W-1:0] mag;
    } sm_t;

    typedef logic [LANES-1:0][X_W-1:0]    xq_t;
    typedef logic [LANES-1:0][DREM_W-1:0] rem_t;

    // Signed-magnitude addition.
    function automatic sm_t sm_add(input logic s1, input logic [NUM_W-1:0] m1,
                                   input logic s2, input logic [NUM_W-1:0] m2);
        sm_t r;
        if (s1 == s2)
        begin
            r.neg = s1;
            r.mag = m1 + m2;
        end
        else if (m1 >= m2)
        begin
            r.neg = s1;
            r.mag = m1 - m2;
        end
        else
        begin
            r.neg = s2;
            r.mag = m2 - m1;
        end
        return r;
    endfunction

    logic             [NUM_W-1:0] b_ext;
    logic             [NUM_W-1:0] s_ext;
    sm_t              num [LANES];
    dctl_t            prep_ctl_next;
    xq_t              prep_x_next;

    logic             prep_valid_reg;
    xq_t              prep_x_reg;
    logic [DVS_W-1:0] prep_dvs_reg;
    dctl_t            prep_ctl_reg;

    logic             vld_in   [X_W];
    logic             vld_reg  [X_W];
    dctl_t            ctl_in   [X_W];
    dctl_t            ctl_reg  [X_W];
    xq_t              xq_in    [X_W];
    xq_t              xq_next  [X_W];
    xq_t              xq_reg   [X_W];
    rem_t             rem_in   [X_W];
    rem_t             rem_next [X_W];
    rem_t             rem_reg  [X_W];
    logic [DVS_W-1:0] dvs_in   [X_W];
    logic [DVS_W-1:0] dvs_reg  [X_W];

    // Classification and the three numerators with their quotient signs.
    always_comb
    begin
        b_ext = NUM_W'(s_ctl.b_mag);
        s_ext = NUM_W'(s_root);
        if (s_ctl.a_zero)
        begin
            prep_ctl_next.kind = KIND_REJECT;
        end
        else if (s_root == '0)
        begin
            prep_ctl_next.kind = KIND_DOUBLE;
        end
        else if (s_ctl.d_neg)
        begin
            prep_ctl_next.kind = KIND_COMPLEX;
        end
        else
        begin
            prep_ctl_next.kind = KIND_DISTINCT;
        end

        if (prep_ctl_next.kind == KIND_DISTINCT)
        begin
            num[0] = sm_add(s_ctl.nb_neg, b_ext, 1'b0, s_ext);
            num[1] = sm_add(s_ctl.nb_neg, b_ext, 1'b1, s_ext);
        end
        else
        begin
            num[0] = {s_ctl.nb_neg, b_ext};
            num[1] = {s_ctl.nb_neg, b_ext};
        end
        num[2] = {1'b0, s_ext};

        // Adding |a| before dividing by 2|a| rounds the quotient to nearest.
        for (int l = 0; l < LANES; l++)
        begin
            prep_x_next[l]         = (X_W'(num[l].mag) << FRAC_BITS) + X_W'(s_ctl.a_mag);
            prep_ctl_next.q_neg[l] = num[l].neg ^ s_ctl.a_neg;
        end
    end

    // Restoring division, one quotient bit per stage; quotient bits replace dividend bits.
    genvar k;
    for (k = 0; k < X_W; k++)
    begin : g_stage
        if (k == 0)
        begin : g_first
            assign vld_in[k] = prep_valid_reg;
            assign ctl_in[k] = prep_ctl_reg;
            assign xq_in[k]  = prep_x_reg;
            assign rem_in[k] = '0;
            assign dvs_in[k] = prep_dvs_reg;
        end
        else
        begin : g_later
            assign vld_in[k] = vld_reg[k-1];
            assign ctl_in[k] = ctl_reg[k-1];
            assign xq_in[k]  = xq_reg[k-1];
            assign rem_in[k] = rem_reg[k-1];
            assign dvs_in[k] = dvs_reg[k-1];
        end

        always_comb
        begin
            logic [DREM_W-1:0] r_sh;
            logic [DREM_W-1:0] dvs_ext;
            logic              ge;
            dvs_ext = DREM_W'(dvs_in[k]);
            for (int l = 0; l < LANES; l++)
            begin
                r_sh           = {rem_in[k][l][DREM_W-2:0], xq_in[k][l][X_W-1]};
                ge             = (r_sh >= dvs_ext);
                rem_next[k][l] = ge ? (r_sh - dvs_ext) : r_sh;
                xq_next[k][l]  = {xq_in[k][l][X_W-2:0], ge};
            end
        end
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prep_valid_reg <= 1'b0;
            for (int i = 0; i < X_W; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            prep_valid_reg <= s_valid;
            for (int i = 0; i < X_W; i++)
            begin
                vld_reg[i] <= vld_in[i];
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prep_x_reg   <= prep_x_next;
            prep_dvs_reg <= {s_ctl.a_mag, 1'b0};
            prep_ctl_reg <= prep_ctl_next;
            for (int i = 0; i < X_W; i++)
            begin
                xq_reg[i]  <= xq_next[i];
                rem_reg[i] <= rem_next[i];
                dvs_reg[i] <= dvs_in[i];
                ctl_reg[i] <= ctl_in[i];
            end
        end
    end

    assign q_valid = vld_reg[LAST];
    assign q_quot  = xq_reg[LAST];
    assign q_ctl   = ctl_reg[LAST];

endmodule

// ===== design/quadratic_root_solver.sv =====
// Throughput: one transaction per cycle while the output is not held; the 33-stage square
// root and the 51-stage divider each retire one bit per stage, so every stage takes a new
// item each cycle. While a result waits on the output, the whole pipeline holds and
// nothing is lost.
// Reset (rst_n, asynchronous, active low) clears every valid bit; data is not reset.
module quadratic_root_solver (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  qrs_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output qrs_pkg::out_t out_data
);
    import qrs_pkg::*;

    typedef struct packed {
        logic                  clip;
        logic [WORD_WIDTH-1:0] word;
    } sat_t;

    // Saturate a rounded quotient magnitude and apply its sign.
    function automatic sat_t sat_word(input logic [X_W-1:0] q, input logic neg);
        sat_t                  r;
        logic [WORD_WIDTH-1:0] m;
        if (!neg)
        begin
            r.clip = |q[X_W-1:WORD_WIDTH-1];
            r.word = r.clip ? {1'b0, {(WORD_WIDTH-1){1'b1}}} : q[WORD_WIDTH-1:0];
        end
        else
        begin
            r.clip = (|q[X_W-1:WORD_WIDTH]) | (q[WORD_WIDTH-1] & (|q[WORD_WIDTH-2:0]));
            m      = r.clip ? {1'b1, {(WORD_WIDTH-1){1'b0}}} : q[WORD_WIDTH-1:0];
            r.word = ~m + 1'b1;
        end
        return r;
    endfunction

    logic                          adv;
    logic                          d_valid;
    logic [DISC_W-1:0]             d_mag;
    coef_t                         d_ctl;
    logic                          s_valid;
    logic [ROOT_W-1:0]             s_root;
    coef_t                         s_ctl;
    logic                          q_valid;
    logic [LANES-1:0][X_W-1:0]     q_quot;
    dctl_t                         q_ctl;

    sat_t                          r1_re;
    sat_t                          r2_re;
    sat_t                          r1_im;
    sat_t                          r2_im;
    out_t                          out_next;
    logic                          out_valid_reg;
    out_t                          out_data_reg;

    // The pipeline moves whenever the output register is empty or being taken.
    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    qrs_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (in_valid),
        .in_data  (in_data),
        .d_valid  (d_valid),
        .d_mag    (d_mag),
        .d_ctl    (d_ctl)
    );

    qrs_sqrt u_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .d_valid (d_valid),
        .d_mag   (d_mag),
        .d_ctl   (d_ctl),
        .s_valid (s_valid),
        .s_root  (s_root),
        .s_ctl   (s_ctl)
    );

    qrs_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .s_valid (s_valid),
        .s_root  (s_root),
        .s_ctl   (s_ctl),
        .q_valid (q_valid),
        .q_quot  (q_quot),
        .q_ctl   (q_ctl)
    );

    // Assemble the result fields from the three quotients.
    always_comb
    begin
        r1_re = sat_word(q_quot[0], q_ctl.q_neg[0]);
        r2_re = sat_word(q_quot[1], q_ctl.q_neg[1]);
        r1_im = sat_word(q_quot[2], q_ctl.q_neg[2]);
        r2_im = sat_word(q_quot[2], !q_ctl.q_neg[2]);

        out_next.root_kind = q_ctl.kind;
        out_next.root1_re  = r1_re.word;
        out_next.root2_re  = r2_re.word;
        out_next.root1_im  = '0;
        out_next.root2_im  = '0;
        out_next.clipped   = r1_re.clip | r2_re.clip;
        case (q_ctl.kind)
            KIND_COMPLEX:
            begin
                out_next.root1_im = r1_im.word;
                out_next.root2_im = r2_im.word;
                out_next.clipped  = r1_re.clip | r2_re.clip | r1_im.clip | r2_im.clip;
            end
            KIND_REJECT:
            begin
                out_next.root1_re = '0;
                out_next.root2_re = '0;
                out_next.clipped  = 1'b0;
            end
            default:
            begin
                out_next.root1_im = '0;
            end
        endcase
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= q_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef SYNTHESIS
    // A rejected equation carries all-zero roots and no saturation.
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.root_kind == KIND_REJECT |->
            out_data.root1_re == '0 && out_data.root2_re == '0 &&
            out_data.root1_im == '0 && out_data.root2_im == '0 && !out_data.clipped)
        else $error("rejected transaction has nonzero roots or clip");

    // Real roots have no imaginary parts.
    a_real_no_im: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.root_kind == KIND_DISTINCT ||
                      out_data.root_kind == KIND_DOUBLE) |->
            out_data.root1_im == '0 && out_data.root2_im == '0)
        else $error("real roots carry an imaginary part");

    // A double root and a complex pair share one real part.
    a_shared_re: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.root_kind == KIND_DOUBLE ||
                      out_data.root_kind == KIND_COMPLEX) |->
            out_data.root1_re == out_data.root2_re)
        else $error("real parts of a double root or complex pair differ");

    // Without saturation, the imaginary parts of a complex pair are exact negatives.
    a_complex_im: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.root_kind == KIND_COMPLEX && !out_data.clipped |->
            out_data.root1_im == -out_data.root2_im)
        else $error("unclipped complex pair is not conjugate");
`endif

endmodule

// ===== tb/sv/quadratic_root_solver_checker.sv =====
module quadratic_root_solver_checker
    import qrs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic in_ready,
    input  in_t  in_data,
    input  logic out_valid,
    input  logic out_ready,
    input  out_t out_data,
    output int   error_count,
    output int   pending_roots
);

    localparam logic [127:0] HALF_WORD = 128'd1 << (WORD_WIDTH - 1);

    out_t expected_roots[$];

    // Rounded square root of a nonnegative value, found bit by bit.
    function automatic logic [127:0] round_sqrt(input logic [127:0] radicand);
        logic [127:0] r;
        logic [127:0] c;
        r = '0;
        for (int i = 63; i >= 0; i--)
        begin
            c = r | (128'd1 << i);
            if (c * c <= radicand)
                r = c;
        end
        if (radicand - r * r > r)
            r = r + 1;
        return r;
    endfunction

    // One root part: N * 2^F / (2A), rounded half away from zero and saturated.
    function automatic logic [WORD_WIDTH-1:0] scale_root(input logic signed [127:0] numer,
                                                        input logic signed [127:0] a_val,
                                                        inout logic clip);
        logic [127:0] n_mag;
        logic [127:0] a_mag;
        logic [127:0] q;
        logic         negative;
        n_mag = numer < 0 ? -numer : numer;
        a_mag = a_val < 0 ? -a_val : a_val;
        negative = (numer < 0) != (a_val < 0);
        q = ((n_mag << FRAC_BITS) + a_mag) / (a_mag << 1);
        if (!negative)
        begin
            if (q > HALF_WORD - 1)
            begin
                clip = 1'b1;
                q = HALF_WORD - 1;
            end
            return q[WORD_WIDTH-1:0];
        end
        if (q > HALF_WORD)
        begin
            clip = 1'b1;
            q = HALF_WORD;
        end
        return -q[WORD_WIDTH-1:0];
    endfunction

    // Expected roots of one equation.
    function automatic out_t solve_equation(input in_t coefs);
        out_t                 r;
        logic signed [127:0]  a;
        logic signed [127:0]  b;
        logic signed [127:0]  c;
        logic signed [127:0]  disc;
        logic signed [127:0]  s;
        logic                 clip;
        r = '0;
        clip = 1'b0;
        a = coefs.coef_a;
        b = coefs.coef_b;
        c = coefs.coef_c;
        if (a == 0)
        begin
            r.root_kind = KIND_REJECT;
            return r;
        end
        disc = b * b - 4 * a * c;
        if (disc == 0)
        begin
            r.root_kind = KIND_DOUBLE;
            r.root1_re = scale_root(-b, a, clip);
            r.root2_re = r.root1_re;
        end
        else if (disc > 0)
        begin
            r.root_kind = KIND_DISTINCT;
            s = round_sqrt(disc);
            r.root1_re = scale_root(-b + s, a, clip);
            r.root2_re = scale_root(-b - s, a, clip);
        end
        else
        begin
            r.root_kind = KIND_COMPLEX;
            s = round_sqrt(-disc);
            r.root1_re = scale_root(-b, a, clip);
            r.root2_re = r.root1_re;
            r.root1_im = scale_root(s, a, clip);
            r.root2_im = scale_root(-s, a, clip);
        end
        r.clipped = clip;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("Mismatch on %s: got %h, expected %h", what, got, want);
        error_count++;
    endtask

    initial
    begin
        error_count = 0;
        pending_roots = 0;
    end

    // Record each input transaction and check each output transaction.
    always @(posedge clk)
    begin
        out_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                expected_roots.push_back(solve_equation(in_data));
            if (out_valid && out_ready)
            begin
                if (expected_roots.size() == 0)
                    report_mismatch("unexpected result", 32'd0, 32'd0);
                else
                begin
                    want = expected_roots.pop_front();
                    if (out_data.root1_re !== want.root1_re)
                        report_mismatch("root1_re", out_data.root1_re, want.root1_re);
                    if (out_data.root1_im !== want.root1_im)
                        report_mismatch("root1_im", out_data.root1_im, want.root1_im);
                    if (out_data.root2_re !== want.root2_re)
                        report_mismatch("root2_re", out_data.root2_re, want.root2_re);
                    if (out_data.root2_im !== want.root2_im)
                        report_mismatch("root2_im", out_data.root2_im, want.root2_im);
                    if (out_data.root_kind !== want.root_kind)
                        report_mismatch("root_kind", out_data.root_kind, want.root_kind);
                    if (out_data.clipped !== want.clipped)
                        report_mismatch("clipped", out_data.clipped, want.clipped);
                end
            end
        end
        pending_roots = expected_roots.size();
    end

endmodule

// ===== tb/sv/quadratic_root_solver_test.sv =====
module quadratic_root_solver_test;
    import qrs_pkg::*;

    localparam int RANDOM_EQUATIONS = 600;
    localparam int CYCLE_LIMIT      = 200000;
    localparam int DRAIN_CYCLES     = 120;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    in_t  in_data;
    logic out_valid;
    logic out_ready;
    out_t out_data;
    int   error_count;
    int   pending_roots;
    int   cycle_count;
    logic stall_window;

    quadratic_root_solver i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    quadratic_root_solver_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_data       (in_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_data      (out_data),
        .error_count   (error_count),
        .pending_roots (pending_roots)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // Watchdog on the total run length.
    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic int random_gap();
        if ($urandom_range(0, 9) < 6)
            return 0;
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Coefficient mix: full random words, small values and extremes.
    function automatic logic [31:0] random_coef();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return $signed($urandom_range(0, 2 ** 20)) - (2 ** 19);
            2: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom())};
            3: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            4: return ($signed($urandom_range(0, 16)) - 8) <<< 16;
            default: return $urandom() >> $urandom_range(0, 31);
        endcase
    endfunction

    // Offer one transaction and hold it until accepted.
    task automatic send_equation(input logic [31:0] a, input logic [31:0] b,
                                 input logic [31:0] c);
        in_data.coef_a <= a;
        in_data.coef_b <= b;
        in_data.coef_c <= c;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_with_gap(input logic [31:0] a, input logic [31:0] b,
                                 input logic [31:0] c);
        int gap;
        gap = random_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        send_equation(a, b, c);
    endtask

    // Receiver: random stalls, with one long hold-off early in the run.
    initial
    begin
        int gap;
        out_ready = 1'b0;
        stall_window = 1'b1;
        @(posedge rst_n);
        @(negedge clk);
        repeat (300) @(negedge clk);
        stall_window = 1'b0;
        forever
        begin
            out_ready <= 1'b1;
            @(negedge clk);
            gap = random_gap();
            if (gap > 0 && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
    end

    initial
    begin
        int r;
        int m;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed equations, sent back to back while the output is held off.
        send_equation(32'h00010000, 32'hfffd0000, 32'h00020000);  // two real roots
        send_equation(32'h00010000, 32'hfffe0000, 32'h00010000);  // double root
        send_equation(32'h00010000, 32'h00000000, 32'h00010000);  // complex pair
        send_equation(32'h00000000, 32'h00050000, 32'h00030000);  // a is zero
        send_equation(32'h00000000, 32'h00000000, 32'h00000000);
        send_equation(32'h00000001, 32'h7fffffff, 32'h00000000);  // real root saturates
        send_equation(32'h00000001, 32'h80000000, 32'h80000000);
        send_equation(32'h00000001, 32'h00000000, 32'h7fffffff);  // imaginary saturates
        send_equation(32'hffffffff, 32'h00000000, 32'h80000000);
        send_equation(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        send_equation(32'h80000000, 32'h80000000, 32'h80000000);
        send_equation(32'h80000000, 32'h7fffffff, 32'h7fffffff);
        send_equation(32'hffffffff, 32'hffffffff, 32'hffffffff);
        send_equation(32'h00000001, 32'h00000002, 32'h00000001);
        send_equation(32'hffff0000, 32'h00000000, 32'h00040000);
        send_equation(32'h00020000, 32'h00000001, 32'h00000000);
        send_equation(32'h00010000, 32'h00000000, 32'h00000000);
        send_equation(32'h55555555, 32'haaaaaaaa, 32'h55555555);
        send_equation(32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa);

        // Random equations; the first ones pile up against the held output.
        for (int i = 0; i < RANDOM_EQUATIONS; i++)
        begin
            r = $urandom_range(1, 8) <<< 16;
            m = $urandom_range(0, 9);
            if (m == 0)
                // Built from a chosen integer root, so always a double root.
                send_with_gap(32'h00010000, -(2 * r), (r >>> 16) * r);
            else if (m == 1)
                send_with_gap(32'h00000000, random_coef(), random_coef());
            else if (stall_window)
                send_equation(random_coef(), random_coef(), random_coef());
            else
                send_with_gap(random_coef(), random_coef(), random_coef());
        end
        in_valid <= 1'b0;

        while (pending_roots != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/qrs_pkg.sv
design/qrs_front.sv
design/qrs_sqrt.sv
design/qrs_div.sv
design/quadratic_root_solver.sv
tb/sv/quadratic_root_solver_checker.sv
tb/sv/quadratic_root_solver_test.sv
